>>> hw/rtl/opg_pkg.sv
// Shared types and constants of the orbit position generator.
`default_nettype none

package opg_pkg;

   // Fraction width of the sine and cosine series arithmetic.
   localparam int FRAC_W = 36;
   localparam int TRIG_W = 16;
   localparam int HORNER_STEPS = 6;

   typedef logic [FRAC_W:0] frac_type;

   // One quarter turn in radians, scaled by 2^FRAC_W.
   localparam frac_type HALF_PI  = 37'h19_21FB_5444;
   localparam frac_type ONE_FRAC = 37'h10_0000_0000;

   // Horner coefficients: reciprocal factorials scaled by 2^FRAC_W, highest order first.
   localparam frac_type SIN_INIT = 37'd1722;
   localparam frac_type COS_INIT = 37'd143;
   localparam frac_type SIN_COEF [HORNER_STEPS] = '{
      37'd189372, 37'd13634817, 37'd572662306, 37'd11453246123, ONE_FRAC, '0
   };
   localparam frac_type COS_COEF [HORNER_STEPS] = '{
      37'd18937, 37'd1704352, 37'd95443718, 37'd2863311531, 37'd34359738368, ONE_FRAC
   };

   typedef struct packed {
      logic signed [TRIG_W-1:0] sn;
      logic signed [TRIG_W-1:0] cs;
   } trig_type;

   typedef enum logic [2:0] {
      REG_PERIOD = 3'd0,
      REG_PHASE  = 3'd1,
      REG_AXIS   = 3'd2,
      REG_ECC    = 3'd3,
      REG_INCL   = 3'd4,
      REG_NODE   = 3'd5
   } reg_type;

endpackage

`default_nettype wire

>>> hw/rtl/orbit_position_generator.sv
// Top level of the orbit position generator: registers, pipeline control and rotation.
//
// Usage: program the orbit through the csr_ register port while no item is in flight,
// then stream time ticks on req_ (tdata holds time_tick). For every item one result
// item leaves on rsp_ carrying x, y, z and the distance from the primary.
// The phase divider has an input stage and 32 + ANGLE_BITS step stages, the sine and
// cosine pipelines 10, and the radius divider AXIS_BITS + 2 stages; the rest are
// product and saturation stages. Throughput is one item per cycle while the receiver
// does not stall; every stage holds its own item.
// When the receiver stalls, the whole pipeline holds and req_tready falls until the
// result register is emptied; no item is dropped or repeated.
// Reset empties the pipeline and loads the registers: period 1, everything else 0.
// A zero period behaves as a period of one.
`default_nettype none

module orbit_position_generator import opg_pkg::*; #(
   parameter int ANGLE_BITS = 16,
   parameter int AXIS_BITS  = 24
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [31:0] req_tdata,   // time_tick
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // pos_x, pos_y, pos_z, radius from bit 0 up, zero padded to whole bytes
   output logic [((4*AXIS_BITS+14)/8)*8-1:0] rsp_tdata,
   input  logic csr_psel,
   input  logic csr_penable,
   input  logic csr_pwrite,
   input  logic [((AXIS_BITS > 32) ? 6 : 5)-1:0] csr_paddr,
   input  logic [((AXIS_BITS > 32) ? 64 : 32)-1:0] csr_pwdata,
   output logic [((AXIS_BITS > 32) ? 64 : 32)-1:0] csr_prdata,
   output logic csr_pready
);

   localparam int POS_W   = AXIS_BITS + 2;
   localparam int RAD_W   = AXIS_BITS + 1;
   localparam int RSP_W   = ((4*AXIS_BITS+14)/8)*8;
   localparam int CSR_DW  = (AXIS_BITS > 32) ? 64 : 32;
   localparam int CSR_AW  = (AXIS_BITS > 32) ? 6 : 5;
   localparam int NUM_W   = RAD_W + 32;
   localparam int DIR_W   = 34;
   localparam int SH_W    = RAD_W + 1 + DIR_W - 30;
   localparam int PROD_W  = RAD_W + 1 + DIR_W;
   localparam int PH_IDX  = 32 + ANGLE_BITS + 2;
   localparam int SCO     = PH_IDX + 3 + HORNER_STEPS + 1;
   localparam int TOTAL   = SCO + 5 + RAD_W;

   typedef struct packed {
      logic signed [DIR_W-1:0] tx;
      logic signed [DIR_W-1:0] ty;
      logic signed [DIR_W-1:0] tz;
   } dir_type;

   function automatic logic [POS_W-1:0] sat_pos(input logic signed [SH_W-1:0] v);
      logic fits;
      fits = (v[SH_W-1:POS_W-1] == '0) || (v[SH_W-1:POS_W-1] == '1);
      if (fits) begin
         return v[POS_W-1:0];
      end
      return v[SH_W-1] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
   endfunction

   // Configuration registers.
   logic [31:0]           period_ff;
   logic [ANGLE_BITS-1:0] init_phase_ff;
   logic [AXIS_BITS-1:0]  axis_ff;
   logic [15:0]           ecc_ff;
   logic [ANGLE_BITS-1:0] incl_ff;
   logic [ANGLE_BITS-1:0] node_ff;
   logic                  csr_wr;
   logic [2:0]            csr_idx;

   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = csr_paddr[CSR_AW-1:CSR_AW-3];
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff     <= 32'd1;
         init_phase_ff <= '0;
         axis_ff       <= '0;
         ecc_ff        <= '0;
         incl_ff       <= '0;
         node_ff       <= '0;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_PERIOD: period_ff     <= csr_pwdata[31:0];
            REG_PHASE:  init_phase_ff <= csr_pwdata[ANGLE_BITS-1:0];
            REG_AXIS:   axis_ff       <= csr_pwdata[AXIS_BITS-1:0];
            REG_ECC:    ecc_ff        <= csr_pwdata[15:0];
            REG_INCL:   incl_ff       <= csr_pwdata[ANGLE_BITS-1:0];
            REG_NODE:   node_ff       <= csr_pwdata[ANGLE_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_PERIOD: csr_prdata = CSR_DW'(period_ff);
         REG_PHASE:  csr_prdata = CSR_DW'(init_phase_ff);
         REG_AXIS:   csr_prdata = CSR_DW'(axis_ff);
         REG_ECC:    csr_prdata = CSR_DW'(ecc_ff);
         REG_INCL:   csr_prdata = CSR_DW'(incl_ff);
         REG_NODE:   csr_prdata = CSR_DW'(node_ff);
         default:    csr_prdata = '0;
      endcase
   end

   // Pipeline control: every stage moves together whenever the result register can take an item.
   logic             en;
   logic [TOTAL-1:0] vld_ff;
   logic [TOTAL-1:0] vld_in;

   assign en         = !vld_ff[TOTAL-1] || rsp_tready;
   assign req_tready = en;
   assign rsp_tvalid = vld_ff[TOTAL-1];
   assign vld_in     = {vld_ff[TOTAL-2:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   // Phase.
   logic [31:0]           per_eff;
   logic [ANGLE_BITS-1:0] frac;
   logic [ANGLE_BITS-1:0] ph_ff;
   logic [ANGLE_BITS-1:0] ph_in;

   assign per_eff = (period_ff == '0) ? 32'd1 : period_ff;
   assign ph_in   = frac + init_phase_ff;

   opg_phase_div #(.ANGLE_BITS(ANGLE_BITS)) u_phase_div (
      .clock     (clock),
      .en        (en),
      .time_tick (req_tdata),
      .period    (per_eff),
      .frac      (frac)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         ph_ff <= ph_in;
      end
   end

   // Sines and cosines of phase, node and inclination.
   trig_type trig_ph, trig_node, trig_incl;

   opg_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_sc_phase (
      .clock (clock),
      .en    (en),
      .angle (ph_ff),
      .trig  (trig_ph)
   );

   opg_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_sc_node (
      .clock (clock),
      .en    (en),
      .angle (node_ff),
      .trig  (trig_node)
   );

   opg_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_sc_incl (
      .clock (clock),
      .en    (en),
      .angle (incl_ff),
      .trig  (trig_incl)
   );

   // Radius numerator and denominator.
   logic signed [32:0] ecp_ff, ecp_in;
   logic [31:0]        esq_ff, esq_in;
   logic [32:0]        one_m_esq;
   logic signed [33:0] dsum;
   logic [32:0]        d_ff, d_in;
   logic [NUM_W-1:0]   num_ff, num_in;
   logic [RAD_W-1:0]   rad;

   always_comb begin
      ecp_in    = $signed({1'b0, ecc_ff}) * trig_ph.cs;
      esq_in    = ecc_ff * ecc_ff;
      one_m_esq = 33'h1_0000_0000 - {1'b0, esq_ff};
      dsum      = 34'sh1_0000_0000 + $signed({ecp_ff, 1'b0});
      d_in      = dsum[32:0];
      num_in    = NUM_W'(axis_ff) * NUM_W'(one_m_esq);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ecp_ff <= ecp_in;
         esq_ff <= esq_in;
         d_ff   <= d_in;
         num_ff <= num_in;
      end
   end

   opg_radius_div #(.Q_W(RAD_W)) u_radius_div (
      .clock (clock),
      .en    (en),
      .num   (num_ff),
      .den   (d_ff),
      .quot  (rad)
   );

   // Direction of the body in Q30, rotated by node and inclination.
   logic signed [31:0] pa_ff, pb_ff, pc_ff, pd_ff, tz1_ff;
   logic signed [15:0] ci_ff;
   logic signed [31:0] pa2_ff, pd2_ff, tz2_ff;
   logic signed [47:0] pbci_ff, pcci_ff, pbci_in, pcci_in;
   dir_type            dir_in;
   dir_type            dly_ff [RAD_W+1];

   always_ff @(posedge clock) begin
      if (en) begin
         pa_ff   <= trig_node.cs * trig_ph.cs;
         pb_ff   <= trig_node.sn * trig_ph.sn;
         pc_ff   <= trig_node.cs * trig_ph.sn;
         pd_ff   <= trig_node.sn * trig_ph.cs;
         tz1_ff  <= trig_ph.sn * trig_incl.sn;
         ci_ff   <= trig_incl.cs;
         pbci_ff <= pbci_in;
         pcci_ff <= pcci_in;
         pa2_ff  <= pa_ff;
         pd2_ff  <= pd_ff;
         tz2_ff  <= tz1_ff;
         dly_ff[0] <= dir_in;
         for (int i = 1; i <= RAD_W; i++) begin
            dly_ff[i] <= dly_ff[i-1];
         end
      end
   end

   always_comb begin
      pbci_in   = 48'(pb_ff) * 48'(ci_ff);
      pcci_in   = 48'(pc_ff) * 48'(ci_ff);
      dir_in.tx = DIR_W'(pa2_ff) - DIR_W'(pbci_ff >>> 15);
      dir_in.ty = DIR_W'(pd2_ff) + DIR_W'(pcci_ff >>> 15);
      dir_in.tz = DIR_W'(tz2_ff);
   end

   // Scale the direction by the radius, then saturate into the result register.
   logic signed [PROD_W-1:0] mx, my, mz;
   logic signed [SH_W-1:0]   sx_ff, sy_ff, sz_ff;
   logic [RAD_W-1:0]         rad1_ff, rad2_ff;
   logic [POS_W-1:0]         px_ff, py_ff, pz_ff;

   always_comb begin
      mx = PROD_W'($signed({1'b0, rad})) * PROD_W'(dly_ff[RAD_W].tx);
      my = PROD_W'($signed({1'b0, rad})) * PROD_W'(dly_ff[RAD_W].ty);
      mz = PROD_W'($signed({1'b0, rad})) * PROD_W'(dly_ff[RAD_W].tz);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sx_ff   <= mx[PROD_W-1:30];
         sy_ff   <= my[PROD_W-1:30];
         sz_ff   <= mz[PROD_W-1:30];
         rad1_ff <= rad;
         px_ff   <= sat_pos(sx_ff);
         py_ff   <= sat_pos(sy_ff);
         pz_ff   <= sat_pos(sz_ff);
         rad2_ff <= rad1_ff;
      end
   end

   assign rsp_tdata = RSP_W'({rad2_ff, pz_ff, py_ff, px_ff});

endmodule

`default_nettype wire

>>> hw/rtl/opg_phase_div.sv
// Pipelined restoring divider that turns a time tick into a fractional orbit phase.
`default_nettype none

module opg_phase_div import opg_pkg::*; #(
   parameter int ANGLE_BITS = 16
) (
   input  logic                  clock,
   input  logic                  en,
   input  logic [31:0]           time_tick,
   input  logic [31:0]           period,
   output logic [ANGLE_BITS-1:0] frac
);

   localparam int STEPS = 32 + ANGLE_BITS;

   logic [31:0]           rem_ff [STEPS+1];
   logic [31:0]           num_ff [STEPS+1];
   logic [ANGLE_BITS-1:0] q_ff   [STEPS+1];

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= '0;
         num_ff[0] <= time_tick;
         q_ff[0]   <= '0;
      end
   end

   // Low quotient bits of (t * 2^ANGLE_BITS) / period equal the phase fraction of t mod period.
   for (genvar k = 0; k < STEPS; k++) begin : g_step
      logic [32:0]           cand;
      logic                  ge;
      logic [31:0]           rem_in;
      logic [ANGLE_BITS-1:0] q_in;

      always_comb begin
         cand   = {rem_ff[k], num_ff[k][31]};
         ge     = cand >= {1'b0, period};
         rem_in = ge ? 32'(cand - {1'b0, period}) : cand[31:0];
         q_in   = {q_ff[k][ANGLE_BITS-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k+1] <= rem_in;
            num_ff[k+1] <= {num_ff[k][30:0], 1'b0};
            q_ff[k+1]   <= q_in;
         end
      end
   end

   assign frac = q_ff[STEPS];

endmodule

`default_nettype wire

>>> hw/rtl/opg_sincos.sv
// Pipelined sine and cosine of an angle in binary turns, rounded to Q1.15.
`default_nettype none

module opg_sincos import opg_pkg::*; #(
   parameter int ANGLE_BITS = 16
) (
   input  logic                  clock,
   input  logic                  en,
   input  logic [ANGLE_BITS-1:0] angle,
   output trig_type              trig
);

   localparam int QA = ANGLE_BITS - 2;
   localparam int SB_DEPTH = 3 + HORNER_STEPS;
   localparam int PW = 2 * FRAC_W + 1;

   typedef struct packed {
      logic [1:0] quad;
      logic       swap;
   } side_type;

   function automatic logic signed [TRIG_W-1:0] round_q15(input frac_type v);
      logic [FRAC_W+1:0] sum;
      logic [FRAC_W-FRAC_W+16:0] r;
      sum = {1'b0, v} + ((FRAC_W+2)'(1) << (FRAC_W - 16));
      r   = sum[FRAC_W+1:FRAC_W-15];
      if (r > 17'd32767) begin
         return 16'sd32767;
      end
      return $signed(r[TRIG_W-1:0]);
   endfunction

   side_type            sb_ff [SB_DEPTH];
   logic [QA-1:0]       red_ff;
   logic [FRAC_W-1:0]   x1_ff;
   logic [FRAC_W-1:0]   xh_ff  [HORNER_STEPS];
   logic [FRAC_W-1:0]   x2h_ff [HORNER_STEPS];
   frac_type            ps_ff  [HORNER_STEPS+1];
   frac_type            pc_ff  [HORNER_STEPS+1];
   trig_type            trig_ff;

   logic [QA-1:0]       r_in;
   logic                swap_in;
   logic [QA-1:0]       red_in;
   logic [QA+FRAC_W:0]  xp_in;
   logic [2*FRAC_W-1:0] sq_in;
   logic signed [TRIG_W-1:0] s15, c15, sa, ca;
   trig_type            trig_in;

   // Fold the quarter turn onto the first octant.
   always_comb begin
      r_in    = angle[QA-1:0];
      swap_in = {r_in, 1'b0} > {1'b1, {QA{1'b0}}};
      red_in  = swap_in ? QA'({1'b1, {QA{1'b0}}} - {1'b0, r_in}) : r_in;
      xp_in   = (QA+FRAC_W+1)'(red_ff) * (QA+FRAC_W+1)'(HALF_PI);
      sq_in   = (2*FRAC_W)'(x1_ff) * (2*FRAC_W)'(x1_ff);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         red_ff    <= red_in;
         sb_ff[0]  <= '{quad: angle[ANGLE_BITS-1:QA], swap: swap_in};
         x1_ff     <= xp_in[QA+FRAC_W-1:QA];
         xh_ff[0]  <= x1_ff;
         x2h_ff[0] <= sq_in[2*FRAC_W-1:FRAC_W];
         ps_ff[0]  <= SIN_INIT;
         pc_ff[0]  <= COS_INIT;
         for (int i = 1; i < SB_DEPTH; i++) begin
            sb_ff[i] <= sb_ff[i-1];
         end
      end
   end

   for (genvar h = 0; h < HORNER_STEPS; h++) begin : g_horner
      logic [PW-1:0] ms, mc;
      frac_type      ps_in, pc_in;

      always_comb begin
         if (h == HORNER_STEPS - 1) begin
            ms = PW'(xh_ff[h]) * PW'(ps_ff[h]);
         end else begin
            ms = PW'(x2h_ff[h]) * PW'(ps_ff[h]);
         end
         mc = PW'(x2h_ff[h]) * PW'(pc_ff[h]);
         // The last sine step multiplies by x instead of subtracting from a coefficient.
         ps_in = (h == HORNER_STEPS - 1) ? ms[PW-1:FRAC_W] : SIN_COEF[h] - ms[PW-1:FRAC_W];
         pc_in = COS_COEF[h] - mc[PW-1:FRAC_W];
      end

      always_ff @(posedge clock) begin
         if (en) begin
            ps_ff[h+1] <= ps_in;
            pc_ff[h+1] <= pc_in;
         end
      end

      if (h < HORNER_STEPS - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (en) begin
               xh_ff[h+1]  <= xh_ff[h];
               x2h_ff[h+1] <= x2h_ff[h];
            end
         end
      end
   end

   always_comb begin
      s15 = round_q15(ps_ff[HORNER_STEPS]);
      c15 = round_q15(pc_ff[HORNER_STEPS]);
      sa  = sb_ff[SB_DEPTH-1].swap ? c15 : s15;
      ca  = sb_ff[SB_DEPTH-1].swap ? s15 : c15;
      case (sb_ff[SB_DEPTH-1].quad)
         2'd0: begin
            trig_in.sn = sa;
            trig_in.cs = ca;
         end
         2'd1: begin
            trig_in.sn = ca;
            trig_in.cs = -sa;
         end
         2'd2: begin
            trig_in.sn = -sa;
            trig_in.cs = -ca;
         end
         default: begin
            trig_in.sn = -ca;
            trig_in.cs = sa;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         trig_ff <= trig_in;
      end
   end

   assign trig = trig_ff;

endmodule

`default_nettype wire

>>> hw/rtl/opg_radius_div.sv
// Pipelined saturating divider for the orbit radius.
`default_nettype none

module opg_radius_div import opg_pkg::*; #(
   parameter int Q_W = 25
) (
   input  logic                clock,
   input  logic                en,
   input  logic [Q_W+31:0]     num,
   input  logic [32:0]         den,
   output logic [Q_W-1:0]      quot
);

   logic [32:0]    rem_ff [Q_W+1];
   logic [Q_W-1:0] lo_ff  [Q_W+1];
   logic [32:0]    d_ff   [Q_W+1];
   logic [Q_W-1:0] q_ff   [Q_W+1];
   logic           sat_ff [Q_W+1];
   logic           sat_in;

   // The quotient overflows its field exactly when the high part of num reaches den.
   assign sat_in = {1'b0, num[Q_W+31:Q_W]} >= den;

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= {1'b0, num[Q_W+31:Q_W]};
         lo_ff[0]  <= num[Q_W-1:0];
         d_ff[0]   <= den;
         q_ff[0]   <= '0;
         sat_ff[0] <= sat_in;
      end
   end

   for (genvar k = 0; k < Q_W; k++) begin : g_step
      logic [33:0]    cand;
      logic           ge;
      logic [32:0]    rem_in;
      logic [Q_W-1:0] q_in;
      logic [Q_W-1:0] lo_in;

      always_comb begin
         cand   = {rem_ff[k], lo_ff[k][Q_W-1]};
         ge     = cand >= {1'b0, d_ff[k]};
         rem_in = ge ? 33'(cand - {1'b0, d_ff[k]}) : cand[32:0];
         q_in   = Q_W'({q_ff[k], ge});
         lo_in  = Q_W'({lo_ff[k], 1'b0});
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k+1] <= rem_in;
            lo_ff[k+1]  <= lo_in;
            d_ff[k+1]   <= d_ff[k];
            q_ff[k+1]   <= q_in;
            sat_ff[k+1] <= sat_ff[k];
         end
      end
   end

   assign quot = sat_ff[Q_W] ? '1 : q_ff[Q_W];

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// Self-checking testbench for the orbit position generator.
`timescale 1ns / 100ps

module tb_top;
   import opg_pkg::*;

   typedef struct packed {
      logic [24:0] radius;
      logic [25:0] pos_z;
      logic [25:0] pos_y;
      logic [25:0] pos_x;
   } fix_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [31:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [103:0] rsp_tdata;
   logic csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [4:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   orbit_position_generator uut (.*);

   always #4 clock = ~clock;

   // Orbit settings as the block holds them.
   logic [31:0] orb_period = 32'd1;
   logic [15:0] orb_phase0 = '0, orb_ecc = '0, orb_incl = '0, orb_node = '0;
   logic [23:0] orb_axis = '0;

   logic [31:0] tick_q[$];
   fix_type fix_q[$];
   int errors = 0;
   int send_gap = 0;
   bit no_idle = 0;

   function automatic logic [63:0] mul_shift(logic [63:0] a, logic [63:0] b, int s);
      logic [127:0] p;
      p = 128'(a) * 128'(b);
      return 64'(p >> s);
   endfunction

   function automatic int round_q15(logic [63:0] v);
      logic [63:0] r;
      r = (v + (64'd1 << 45)) >> 46;
      return (r > 64'd32767) ? 32767 : int'(r);
   endfunction

   // Q1.15 sine and cosine of an angle in 1/65536 turn, by Taylor series in Q61.
   function automatic void trig_q15(input logic [15:0] k, output int sn, output int cs);
      logic [63:0] r, x, x2, ts, tc, s, c;
      logic [1:0] quad;
      bit swap;
      int s15, c15, t;
      quad = k[15:14];
      r = 64'(k[13:0]);
      swap = (2 * r) > 64'd16384;
      if (swap) r = 64'd16384 - r;
      x = mul_shift(64'h3243F6A8885A308D, r, 14);
      x2 = mul_shift(x, x, 61);
      ts = x; s = x;
      tc = 64'd1 << 61; c = tc;
      for (int i = 1; i <= 12; i++) begin
         ts = mul_shift(ts, x2, 61) / 64'((2 * i) * (2 * i + 1));
         tc = mul_shift(tc, x2, 61) / 64'((2 * i - 1) * (2 * i));
         if (i % 2) begin
            s = s - ts; c = c - tc;
         end else begin
            s = s + ts; c = c + tc;
         end
      end
      s15 = round_q15(s);
      c15 = round_q15(c);
      if (swap) begin
         t = s15; s15 = c15; c15 = t;
      end
      case (quad)
         2'd0: begin sn = s15; cs = c15; end
         2'd1: begin sn = c15; cs = -s15; end
         2'd2: begin sn = -s15; cs = -c15; end
         default: begin sn = -c15; cs = s15; end
      endcase
   endfunction

   function automatic logic [25:0] clamp26(longint v);
      if (v > 33554431) v = 33554431;
      if (v < -33554432) v = -33554432;
      return v[25:0];
   endfunction

   function automatic fix_type orbit_fix(logic [31:0] t);
      logic [63:0] per, e;
      logic [15:0] ph;
      logic [127:0] num, d, q;
      int sp, cp, sn, cn, si, ci;
      longint den, r, tx, ty, tz;
      fix_type f;
      per = (orb_period == 0) ? 64'd1 : 64'(orb_period);
      ph = 16'((((64'(t) % per) << 16) / per) + 64'(orb_phase0));
      trig_q15(ph, sp, cp);
      trig_q15(orb_node, sn, cn);
      trig_q15(orb_incl, si, ci);
      e = 64'(orb_ecc);
      num = 128'(orb_axis) * 128'((64'd1 << 32) - e * e);
      den = (longint'(1) << 31) + longint'(orb_ecc) * longint'(cp);
      d = 128'(2 * den);
      q = num / d;
      if (q > 128'h1FFFFFF) q = 128'h1FFFFFF;
      r = longint'(q);
      tx = longint'(cn) * cp - ((longint'(sn) * sp * ci) >>> 15);
      ty = longint'(sn) * cp + ((longint'(cn) * sp * ci) >>> 15);
      tz = longint'(sp) * si;
      f.pos_x = clamp26((r * tx) >>> 30);
      f.pos_y = clamp26((r * ty) >>> 30);
      f.pos_z = clamp26((r * tz) >>> 30);
      f.radius = q[24:0];
      return f;
   endfunction

   function automatic int idle_len();
      if (no_idle || $urandom_range(0, 9) < 6) return 0;
      if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Input side: present the queue front until it is taken.
   always @(negedge clock) begin
      if (reset || send_gap > 0) begin
         req_tvalid <= 1'b0;
         if (!reset) send_gap--;
      end else if (tick_q.size() > 0) begin
         req_tvalid <= 1'b1;
         req_tdata <= tick_q[0];
      end else begin
         req_tvalid <= 1'b0;
      end
   end

   // Receiver, with one long hold-off while a full batch waits, to fill the pipeline.
   int rx_hold = 0;
   bit hold_done = 0;
   always @(negedge clock) begin
      if (!hold_done && no_idle && tick_q.size() > 100) begin
         hold_done = 1;
         rx_hold = 400;
      end
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (rx_hold > 0) begin
         rx_hold--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= (idle_len() == 0);
      end
   end

   always @(posedge clock) begin
      fix_type got, want;
      if (!reset && req_tvalid && req_tready) begin
         fix_q.insert(fix_q.size(), orbit_fix(req_tdata));
         void'(tick_q.pop_front());
         send_gap = idle_len();
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = fix_type'(rsp_tdata[102:0]);
         if (fix_q.size() == 0) begin
            $display("%0t: result with none expected: %h", $time, got);
            errors++;
         end else begin
            want = fix_q.pop_front();
            if (got.pos_x !== want.pos_x) begin
               $display("%0t: pos_x expected %h got %h", $time, want.pos_x, got.pos_x);
               errors++;
            end
            if (got.pos_y !== want.pos_y) begin
               $display("%0t: pos_y expected %h got %h", $time, want.pos_y, got.pos_y);
               errors++;
            end
            if (got.pos_z !== want.pos_z) begin
               $display("%0t: pos_z expected %h got %h", $time, want.pos_z, got.pos_z);
               errors++;
            end
            if (got.radius !== want.radius) begin
               $display("%0t: radius expected %h got %h", $time, want.radius, got.radius);
               errors++;
            end
         end
      end
   end

   task automatic csr_write(reg_type idx, logic [31:0] v);
      @(negedge clock);
      csr_psel <= 1'b1; csr_pwrite <= 1'b1; csr_penable <= 1'b0;
      csr_paddr <= 5'(4 * idx); csr_pwdata <= v;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      case (idx)
         REG_PERIOD: orb_period = v;
         REG_PHASE: orb_phase0 = v[15:0];
         REG_AXIS: orb_axis = v[23:0];
         REG_ECC: orb_ecc = v[15:0];
         REG_INCL: orb_incl = v[15:0];
         default: orb_node = v[15:0];
      endcase
   endtask

   // Upper register bits carry noise; the block must ignore them.
   task automatic set_orbit(logic [31:0] per, logic [15:0] ph0, logic [23:0] a,
                            logic [15:0] e, logic [15:0] inc, logic [15:0] node);
      csr_write(REG_PERIOD, per);
      csr_write(REG_PHASE, {16'($urandom_range(0, 65535)), ph0});
      csr_write(REG_AXIS, {8'($urandom), a});
      csr_write(REG_ECC, {16'($urandom_range(0, 65535)), e});
      csr_write(REG_INCL, {16'hFFFF, inc});
      csr_write(REG_NODE, {16'hA5A5, node});
   endtask

   task automatic drain();
      while (tick_q.size() > 0 || fix_q.size() > 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic random_ticks(int n);
      logic [31:0] t;
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(0, 3))
            0: t = orb_period * $urandom_range(0, 7) + $urandom_range(0, 2) - 1;
            1: t = $urandom_range(0, 1000);
            default: t = $urandom;
         endcase
         tick_q.insert(tick_q.size(), t);
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: reset settings, then extreme ticks and quarter points.
      tick_q = '{32'd0, 32'hFFFFFFFF};
      drain();
      set_orbit(32'd65536, 16'd0, 24'hFFFFFF, 16'hFFFF, 16'h4000, 16'h0000);
      tick_q = '{32'd0, 32'd16384, 32'd32768, 32'd49152, 32'd65535, 32'd8192,
                 32'hFFFFFFFF, 32'd1, 32'd24576};
      drain();
      set_orbit(32'd0, 16'hFFFF, 24'd1, 16'd0, 16'hFFFF, 16'h8000);
      tick_q = '{32'd0, 32'd12345, 32'hFFFFFFFF};
      drain();
      set_orbit(32'hFFFFFFFF, 16'h2000, 24'h800000, 16'h8000, 16'hC000, 16'hFFFF);
      tick_q = '{32'd0, 32'hFFFFFFFE, 32'hFFFFFFFF, 32'h80000000, 32'h40000000};
      drain();

      for (int ph = 0; ph < 6; ph++) begin
         no_idle = (ph == 2);
         if (ph == 5)
            set_orbit(32'd1, 16'($urandom), 24'hFFFFFF, 16'hFFFF, 16'($urandom),
                      16'($urandom));
         else
            set_orbit((ph == 1) ? 32'hFFFFFFFF : $urandom_range(1, 100000),
                      16'($urandom), 24'($urandom), 16'($urandom), 16'($urandom),
                      16'($urandom));
         random_ticks(165);
         drain();
      end

      if (errors == 0 && fix_q.size() == 0)
         $display("orbit_position_generator verification clean");
      else
         $display("orbit_position_generator verification failed");
      $finish;
   end

   initial begin
      #5ms;
      $display("orbit_position_generator verification failed");
      $finish;
   end

endmodule

>>> orbit_position_generator.f
hw/rtl/opg_pkg.sv
hw/rtl/opg_phase_div.sv
hw/rtl/opg_sincos.sv
hw/rtl/opg_radius_div.sv
hw/rtl/orbit_position_generator.sv
tb/tb_top.sv
